FILE: src/ps2mpc_pkg.sv
// Package for the PS/2 mouse packet cursor block.
// Holds the shared types and constants; no dependencies.
`timescale 1ns / 1ps

package ps2mpc_pkg;

    localparam int unsigned PosW   = 13;
    localparam int unsigned DxW    = 9;
    localparam int unsigned DyW    = 10;
    localparam int unsigned BtnW   = 3;
    localparam int unsigned OutW   = 48;

    localparam logic [7:0] AckByte  = 8'hFA;
    localparam logic [7:0] HdrMask  = 8'hC8;
    localparam logic [7:0] HdrMatch = 8'h08;

    localparam logic [PosW-1:0] WidthReset  = 13'd1024;
    localparam logic [PosW-1:0] HeightReset = 13'd768;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_ACK = 2'd0,
        PH_HDR = 2'd1,
        PH_X   = 2'd2,
        PH_Y   = 2'd3
    } phase_t;

    // A complete packet as seen on the beat of its third byte.
    typedef struct packed {
        logic            valid;
        logic [BtnW-1:0] buttons;
        logic            x_sign;
        logic            y_sign;
        logic [7:0]      x_byte;
        logic [7:0]      y_byte;
    } packet_t;

    typedef struct packed {
        logic                  valid;
        logic [PosW-1:0]       cursor_x;
        logic [PosW-1:0]       cursor_y;
        logic [BtnW-1:0]       buttons;
        logic signed [DxW-1:0] delta_x;
        logic signed [DyW-1:0] delta_y;
    } result_t;

endpackage

FILE: src/ps2mpc_frame.sv
// Byte framing for the PS/2 mouse packet cursor block: acknowledge wait,
// header check and storage of the packet bytes. Depends on ps2mpc_pkg.
`timescale 1ns / 1ps

module ps2mpc_frame (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    output ps2mpc_pkg::packet_t packet
);

    ps2mpc_pkg::phase_t phase_reg;
    ps2mpc_pkg::phase_t phase_next;
    logic [7:0]         header_reg;
    logic [7:0]         header_next;
    logic [7:0]         x_byte_reg;
    logic [7:0]         x_byte_next;
    logic               header_ok;

    assign header_ok = (data_byte & ps2mpc_pkg::HdrMask) == ps2mpc_pkg::HdrMatch;

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            ps2mpc_pkg::PH_ACK:
            begin
                if (data_byte == ps2mpc_pkg::AckByte)
                begin
                    phase_next = ps2mpc_pkg::PH_HDR;
                end
            end
            ps2mpc_pkg::PH_HDR:
            begin
                if (header_ok)
                begin
                    phase_next = ps2mpc_pkg::PH_X;
                end
            end
            ps2mpc_pkg::PH_X: phase_next = ps2mpc_pkg::PH_Y;
            ps2mpc_pkg::PH_Y: phase_next = ps2mpc_pkg::PH_HDR;
            default:          phase_next = ps2mpc_pkg::PH_ACK;
        endcase
    end

    // Outputs and byte storage.
    always_comb
    begin
        header_next    = header_reg;
        x_byte_next    = x_byte_reg;
        packet.valid   = 1'b0;
        packet.buttons = header_reg[2:0];
        packet.x_sign  = header_reg[4];
        packet.y_sign  = header_reg[5];
        packet.x_byte  = x_byte_reg;
        packet.y_byte  = data_byte;
        unique case (phase_reg)
            ps2mpc_pkg::PH_ACK: ;
            ps2mpc_pkg::PH_HDR:
            begin
                if (header_ok)
                begin
                    header_next = data_byte;
                end
            end
            ps2mpc_pkg::PH_X: x_byte_next = data_byte;
            ps2mpc_pkg::PH_Y: packet.valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ps2mpc_pkg::PH_ACK;
            header_reg <= 8'h00;
            x_byte_reg <= 8'h00;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            x_byte_reg <= x_byte_next;
        end
    end

endmodule

FILE: src/ps2mpc_cursor.sv
// Cursor update for the PS/2 mouse packet cursor block: delta decode,
// position add and clamp, position registers. Depends on ps2mpc_pkg.
`timescale 1ns / 1ps

module ps2mpc_cursor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  ps2mpc_pkg::packet_t            packet,
    input  logic [ps2mpc_pkg::PosW-1:0]    screen_width,
    input  logic [ps2mpc_pkg::PosW-1:0]    screen_height,
    output ps2mpc_pkg::result_t            result
);

    localparam int unsigned SumW = ps2mpc_pkg::PosW + 2;

    logic [ps2mpc_pkg::PosW-1:0]           pos_x_reg;
    logic [ps2mpc_pkg::PosW-1:0]           pos_y_reg;
    logic signed [ps2mpc_pkg::DxW-1:0]     dx;
    logic signed [ps2mpc_pkg::DyW-1:0]     dy;
    logic signed [SumW-1:0]                sum_x;
    logic signed [SumW-1:0]                sum_y;
    logic [ps2mpc_pkg::PosW-1:0]           new_x;
    logic [ps2mpc_pkg::PosW-1:0]           new_y;

    // Nine-bit movement from the sign bit and the data byte; Y is widened to
    // ten bits and negated so that positive values move down the screen.
    assign dx = {packet.x_sign, packet.x_byte};
    assign dy = ps2mpc_pkg::DyW'(0) - {packet.y_sign, packet.y_sign, packet.y_byte};

    assign sum_x = $signed({2'b00, pos_x_reg}) + SumW'(dx);
    assign sum_y = $signed({2'b00, pos_y_reg}) + SumW'(dy);

    // Lower clamp to zero first, then the upper limit.
    always_comb
    begin
        priority if (sum_x < 0)
        begin
            new_x = '0;
        end
        else if (sum_x > $signed({2'b00, screen_width}))
        begin
            new_x = screen_width;
        end
        else
        begin
            new_x = sum_x[ps2mpc_pkg::PosW-1:0];
        end

        priority if (sum_y < 0)
        begin
            new_y = '0;
        end
        else if (sum_y > $signed({2'b00, screen_height}))
        begin
            new_y = screen_height;
        end
        else
        begin
            new_y = sum_y[ps2mpc_pkg::PosW-1:0];
        end
    end

    assign result.valid    = packet.valid;
    assign result.cursor_x = new_x;
    assign result.cursor_y = new_y;
    assign result.buttons  = packet.buttons;
    assign result.delta_x  = dx;
    assign result.delta_y  = dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else if (step && packet.valid)
        begin
            pos_x_reg <= new_x;
            pos_y_reg <= new_y;
        end
    end

endmodule

FILE: src/ps2_mouse_packet_cursor.sv
// Top level of the PS/2 mouse packet cursor block: input register, config
// registers and result register around ps2mpc_frame and ps2mpc_cursor.
// Depends on ps2mpc_pkg, ps2mpc_frame and ps2mpc_cursor.
`timescale 1ns / 1ps

// Usage
// The slave stream takes one raw mouse byte per beat on s_axis_tdata. After
// reset every byte is dropped until the 0xFA acknowledge byte arrives; from
// then on bytes are framed as three-byte packets. A header byte with bit 3
// clear or an overflow flag set is dropped and the framer keeps looking for
// a header. The third byte of each packet produces one beat on the master
// stream with the clamped cursor, the buttons and the decoded deltas.
// Bytes that complete no packet produce no output beat.
// Timing: a byte is captured in the input register; when it advances it is
// decoded and added to the cursor combinationally, and its result is loaded
// into the output register, which drives m_axis_tvalid. One byte per cycle
// is sustained while the output beats are taken; the cursor add and clamp
// are combinational and close their loop through the position registers.
// Stalls: while the output register holds an untaken beat the input
// register stops, and s_axis_tready drops once that register is full.
// Configuration: cfg_index 0 writes the width limit, 1 the height limit;
// write only while the block is idle. cfg_ready is always high.
// Reset clears the framer to the acknowledge wait, the cursor to zero, the
// limits to 1024 by 768 and empties both registers.

module ps2_mouse_packet_cursor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [12:0] cursor_x, [25:13] cursor_y, [28:26] buttons,
    // [37:29] delta_x, [47:38] delta_y
    output logic [ps2mpc_pkg::OutW-1:0]    m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [ps2mpc_pkg::PosW-1:0]    cfg_data
);

    logic                              in_valid_reg;
    logic [7:0]                        in_byte_reg;
    logic                              advance;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [ps2mpc_pkg::OutW-1:0]       out_data_reg;
    logic [ps2mpc_pkg::PosW-1:0]       width_reg;
    logic [ps2mpc_pkg::PosW-1:0]       height_reg;
    ps2mpc_pkg::packet_t               packet;
    ps2mpc_pkg::result_t               result;
    ps2mpc_pkg::reg_index_t            cfg_sel;

    // The held byte moves on when the output register has room for a result.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign cfg_sel       = ps2mpc_pkg::reg_index_t'(cfg_index);

    ps2mpc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .packet    (packet)
    );

    ps2mpc_cursor u_cursor (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .packet        (packet),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .result        (result)
    );

    always_comb
    begin
        priority if (advance && result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= ps2mpc_pkg::WidthReset;
            height_reg    <= ps2mpc_pkg::HeightReset;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_sel)
                    ps2mpc_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                    ps2mpc_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && result.valid)
        begin
            out_data_reg <= {result.delta_y, result.delta_x, result.buttons,
                             result.cursor_y, result.cursor_x};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
